// ===== rtl/core/scs_pkg.sv =====
package scs_pkg;

  // Default sizing, handed to the top level as parameter defaults
  localparam int DEPTH_DEF      = 128;
  localparam int COST_BITS_DEF  = 16;
  localparam int COORD_BITS_DEF = 8;

  // Fixed port field widths
  localparam int FUNC_W    = 2;
  localparam int COST_W    = 16;
  localparam int COORD_W   = 8;
  localparam int PAY_W     = 32;
  localparam int COUNT_W   = 8;
  localparam int STATUS_W  = 2;

  // Match flags folded per cycle by the search unit
  localparam int SCAN_LANES = 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_SORT   = 2'd2,
    FUNC_SEARCH = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // What every cell of the chain does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP,
    CELL_SORT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     phase;   // odd/even pairing for the transposition step
  } cell_ctl_t;

  typedef struct packed {
    logic [COST_W-1:0]   out_cost;
    logic [COORD_W-1:0]  out_x;
    logic [COORD_W-1:0]  out_y;
    logic [PAY_W-1:0]    out_payload;
    logic                found;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
  } rsp_t;

endpackage

// ===== rtl/core/scs_req_if.sv =====
interface scs_req_if import scs_pkg::*;;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [COST_W-1:0]   entry_cost;
  logic [COORD_W-1:0]  tile_x;
  logic [COORD_W-1:0]  tile_y;
  logic [PAY_W-1:0]    payload;

  modport source (output valid, func, entry_cost, tile_x, tile_y, payload, input ready);
  modport sink   (input valid, func, entry_cost, tile_x, tile_y, payload, output ready);
endinterface

// ===== rtl/core/scs_rsp_if.sv =====
interface scs_rsp_if import scs_pkg::*;;
  logic                valid;
  logic                ready;
  logic [COST_W-1:0]   out_cost;
  logic [COORD_W-1:0]  out_x;
  logic [COORD_W-1:0]  out_y;
  logic [PAY_W-1:0]    out_payload;
  logic                found;
  logic [COUNT_W-1:0]  count;
  logic [STATUS_W-1:0] status;

  modport source (output valid, out_cost, out_x, out_y, out_payload, found, count, status,
                  input ready);
  modport sink   (input valid, out_cost, out_x, out_y, out_payload, found, count, status,
                  output ready);
endinterface

// ===== rtl/core/scs_cell.sv =====
module scs_cell import scs_pkg::*; #(
  parameter int IDX        = 0,
  parameter int DEPTH      = DEPTH_DEF,
  parameter int COST_BITS  = COST_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                                     clk,
  input  cell_ctl_t                                ctl,
  input  logic [CNT_W-1:0]                         count,
  input  logic [COST_BITS+2*COORD_BITS+PAY_W-1:0]  above,
  input  logic [COST_BITS+2*COORD_BITS+PAY_W-1:0]  below,
  input  logic [COORD_BITS-1:0]                    key_x,
  input  logic [COORD_BITS-1:0]                    key_y,
  output logic [COST_BITS+2*COORD_BITS+PAY_W-1:0]  ent,
  output logic                                     hit
);

  localparam int   ENT_W    = COST_BITS + 2*COORD_BITS + PAY_W;
  localparam logic IDX_ODD  = ((IDX % 2) == 1);
  localparam logic [CNT_W-1:0] IDX_SELF = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(IDX + 1);

  logic [COST_BITS-1:0]  self_cost, above_cost, below_cost;
  logic [COORD_BITS-1:0] self_x, self_y;
  logic                  pair_low, pair_high, swap_low, swap_high;

  // Field views of the entry layout {cost, x, y, payload}
  assign self_cost  = ent[ENT_W-1 -: COST_BITS];
  assign above_cost = above[ENT_W-1 -: COST_BITS];
  assign below_cost = below[ENT_W-1 -: COST_BITS];
  assign self_x     = ent[PAY_W+COORD_BITS +: COORD_BITS];
  assign self_y     = ent[PAY_W +: COORD_BITS];

  // Pairing: this cell is the low side of (IDX, IDX+1) or the high side of (IDX-1, IDX)
  always_comb begin
    pair_low  = (ctl.phase == IDX_ODD) && (IDX_NEXT < count);
    pair_high = (IDX > 0) && (ctl.phase != IDX_ODD) && (IDX_SELF < count);
    swap_low  = self_cost > below_cost;
    swap_high = above_cost > self_cost;
  end

  // Tile match, only for occupied cells
  assign hit = (IDX_SELF < count) && (self_x == key_x) && (self_y == key_y);

  // Shift down on push, up on pop, strict compare-exchange on sort
  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_PUSH: ent <= above;
      CELL_POP:  ent <= below;
      CELL_SORT: begin
        if (pair_low && swap_low) begin
          ent <= below;
        end else if (pair_high && swap_high) begin
          ent <= above;
        end
      end
      default: ent <= ent;
    endcase
  end

endmodule

// ===== rtl/core/scs_scan.sv =====
module scs_scan import scs_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DEPTH-1:0] hits,
  output logic             done,
  output logic             found
);

  localparam int GROUPS = (DEPTH + SCAN_LANES - 1) / SCAN_LANES;
  localparam int VEC_W  = GROUPS * SCAN_LANES;
  localparam int GRP_W  = $clog2(GROUPS + 1);

  logic [VEC_W-1:0] vec, load_vec;
  logic [GRP_W-1:0] left;
  logic             busy, acc, acc_next;

  // Pad the flag vector to whole groups, fold the lowest group each cycle
  always_comb begin
    load_vec               = '0;
    load_vec[DEPTH-1:0]    = hits;
    acc_next               = acc | (|vec[SCAN_LANES-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        vec  <= load_vec;
        left <= GRP_W'(GROUPS);
        acc  <= 1'b0;
        busy <= 1'b1;
      end else if (busy) begin
        vec  <= vec >> SCAN_LANES;
        acc  <= acc_next;
        left <= left - 1'b1;
        if (left == GRP_W'(1)) begin
          busy  <= 1'b0;
          done  <= 1'b1;
          found <= acc_next;
        end
      end
    end
  end

endmodule

// ===== rtl/core/sortable_cost_stack.sv =====
// Bounded stack of path-search entries (cost, tile x/y, payload).
// req channel: one transaction per operation (push, pop, sort, search).
// rsp channel: exactly one result transaction per request, in order, carrying
// the popped entry, the search flag, the entry count and a status code.
// Push and pop: the result is registered at acceptance and reaches rsp via the
// output register; a new request can be taken every cycle while rsp is not stalled.
// Sort: an odd-even transposition over the cell chain, one step per cycle,
// as many steps as stored entries (no steps for zero or one entry).
// Search: every cell compares its tile in the acceptance cycle; the flags are
// then folded eight per cycle before the result is written.
// Requests are not taken while a sort or search is running.
// A result waits in a pending register and an output register; while rsp is
// stalled the block keeps working until both are full, then drops req.ready.
// Reset empties the stack (count zero) and clears the valid flags of both result
// registers; the cell contents are not cleared and are never read above the count.
module sortable_cost_stack import scs_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int COST_BITS  = COST_BITS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  scs_req_if.sink   req,
  scs_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ENT_W = COST_BITS + 2*COORD_BITS + PAY_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_SORT, ST_SCAN} state_t;

  state_t            state;
  logic [CNT_W-1:0]  count, count_next, rounds;
  logic              phase;
  cell_ctl_t         ctl;
  logic [ENT_W-1:0]  ent [DEPTH];
  logic [ENT_W-1:0]  above_w [DEPTH];
  logic [ENT_W-1:0]  below_w [DEPTH];
  logic [ENT_W-1:0]  new_ent;
  logic [DEPTH-1:0]  hits;
  logic [COORD_BITS-1:0] key_x, key_y;
  logic              accept, full, empty, scan_start, scan_done, scan_found;
  logic              res_wr, res_valid, out_valid, move;
  rsp_t              res, res_new, out;

  // Incoming entry, cut or widened to the stored widths
  assign key_x   = COORD_BITS'(req.tile_x);
  assign key_y   = COORD_BITS'(req.tile_y);
  assign new_ent = {COST_BITS'(req.entry_cost), key_x, key_y, req.payload};

  // Cell chain: cell 0 is the top of the stack
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign above_w[i] = new_ent;
    end else begin : g_rest
      assign above_w[i] = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign below_w[i] = '0;
    end else begin : g_inner
      assign below_w[i] = ent[i+1];
    end

    scs_cell #(
      .IDX        (i),
      .DEPTH      (DEPTH),
      .COST_BITS  (COST_BITS),
      .COORD_BITS (COORD_BITS),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .count (count),
      .above (above_w[i]),
      .below (below_w[i]),
      .key_x (key_x),
      .key_y (key_y),
      .ent   (ent[i]),
      .hit   (hits[i])
    );
  end

  scs_scan #(
    .DEPTH (DEPTH)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (scan_start),
    .hits  (hits),
    .done  (scan_done),
    .found (scan_found)
  );

  // Handshake: pending result moves on when the output register frees up
  assign move      = res_valid && (!out_valid || rsp.ready);
  assign req.ready = (state == ST_IDLE) && (!res_valid || move);
  assign accept    = req.valid && req.ready;
  assign full      = (count == DEPTH_C);
  assign empty     = (count == '0);

  // Operation decode, cell control and result formation
  always_comb begin
    ctl.op     = CELL_HOLD;
    ctl.phase  = phase;
    res_wr     = 1'b0;
    scan_start = 1'b0;
    count_next = count;
    res_new    = '0;
    res_new.status = STAT_OK;
    if (state == ST_SORT) begin
      ctl.op = CELL_SORT;
    end
    if (accept) begin
      unique case (req.func)
        FUNC_PUSH: begin
          res_wr = 1'b1;
          if (full) begin
            res_new.status = STAT_FULL;
          end else begin
            ctl.op     = CELL_PUSH;
            count_next = count + 1'b1;
          end
        end
        FUNC_POP: begin
          res_wr = 1'b1;
          if (empty) begin
            res_new.status = STAT_EMPTY;
          end else begin
            ctl.op              = CELL_POP;
            count_next          = count - 1'b1;
            res_new.out_cost    = COST_W'(ent[0][ENT_W-1 -: COST_BITS]);
            res_new.out_x       = COORD_W'(ent[0][PAY_W+COORD_BITS +: COORD_BITS]);
            res_new.out_y       = COORD_W'(ent[0][PAY_W +: COORD_BITS]);
            res_new.out_payload = ent[0][PAY_W-1:0];
          end
        end
        FUNC_SORT: begin
          res_wr = (count <= CNT_W'(1));
        end
        FUNC_SEARCH: begin
          scan_start = 1'b1;
        end
      endcase
    end
    if (state == ST_SORT && rounds == CNT_W'(1)) begin
      res_wr = 1'b1;
    end
    if (state == ST_SCAN && scan_done) begin
      res_wr        = 1'b1;
      res_new.found = scan_found;
    end
    res_new.count = COUNT_W'(count_next);
  end

  // Sequencer, stack count and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rounds    <= '0;
      phase     <= 1'b0;
      res_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      unique case (state)
        ST_IDLE: begin
          if (accept && req.func == FUNC_SORT && count > CNT_W'(1)) begin
            state  <= ST_SORT;
            rounds <= count;
            phase  <= 1'b0;
          end else if (accept && req.func == FUNC_SEARCH) begin
            state <= ST_SCAN;
          end
        end
        ST_SORT: begin
          rounds <= rounds - 1'b1;
          phase  <= ~phase;
          if (rounds == CNT_W'(1)) begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (res_wr) begin
        res       <= res_new;
        res_valid <= 1'b1;
      end else if (move) begin
        res_valid <= 1'b0;
      end

      if (move) begin
        out       <= res;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output channel
  assign rsp.valid       = out_valid;
  assign rsp.out_cost    = out.out_cost;
  assign rsp.out_x       = out.out_x;
  assign rsp.out_y       = out.out_y;
  assign rsp.out_payload = out.out_payload;
  assign rsp.found       = out.found;
  assign rsp.count       = out.count;
  assign rsp.status      = out.status;

endmodule

// ===== rtl/core/sortable_cost_stack_chk.sv =====
module sortable_cost_stack_chk import scs_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [COST_W-1:0]   rsp_cost,
  input logic [PAY_W-1:0]    rsp_payload,
  input logic                rsp_found,
  input logic [COUNT_W-1:0]  rsp_count,
  input logic [STATUS_W-1:0] rsp_status
);

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_count)
      && $stable(rsp_cost) && $stable(rsp_payload))
    else $error("result changed while stalled");

  // Pop on empty leaves the stack empty and returns no entry
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == STAT_EMPTY |-> rsp_count == '0 && rsp_cost == '0
      && rsp_payload == '0 && !rsp_found)
    else $error("pop on empty returned data");

  // A search hit comes from a successful search, never with popped data
  a_found_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found |-> rsp_status == STAT_OK && rsp_cost == '0 && rsp_payload == '0)
    else $error("found flag on a non-search result");

  // A dropped push returns nothing
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == STAT_FULL |-> !rsp_found && rsp_cost == '0
      && rsp_payload == '0)
    else $error("dropped push returned data");

endmodule

bind sortable_cost_stack sortable_cost_stack_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_cost    (rsp.out_cost),
  .rsp_payload (rsp.out_payload),
  .rsp_found   (rsp.found),
  .rsp_count   (rsp.count),
  .rsp_status  (rsp.status)
);
